// File: src/fvfvd_pkg.sv
// ----------------------------------------------------------------------------
// fvfvd_pkg
// shared types, codes and helpers of the flexible vertex format decoder
// ----------------------------------------------------------------------------
`default_nettype none

package fvfvd_pkg;

   // field widths
   localparam int CODE_WIDTH   = 32;
   localparam int STREAM_WIDTH = 8;
   localparam int OFFSET_WIDTH = 8;
   localparam int TYPE_WIDTH   = 5;
   localparam int USAGE_WIDTH  = 4;
   localparam int UIDX_WIDTH   = 3;

   // texture coordinate sets
   localparam int TEX_SETS_LIMIT            = 8;
   localparam int DEFAULT_MAX_TEXCOORD_SETS = 8;
   localparam int TEX_COUNT_WIDTH           = 4;
   localparam int TEX_FMT_WIDTH             = 2 * TEX_SETS_LIMIT;
   localparam int TEX_COUNT_LSB             = 8;
   localparam int TEX_FMT_LSB               = 16;

   // queue depths
   localparam int DESC_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH  = 2;

   // position field of the code
   localparam logic [15:0] POS_MASK   = 16'h400E;
   localparam logic [15:0] POS_XYZ    = 16'h0002;
   localparam logic [15:0] POS_XYZRHW = 16'h0004;
   localparam logic [15:0] POS_XYZW   = 16'h4002;
   localparam int          POS_W_BIT  = 14;
   localparam logic [2:0]  POS_XYZB1  = 3'd3;

   // single-bit attributes
   localparam int NORMAL_BIT   = 4;
   localparam int PSIZE_BIT    = 5;
   localparam int DIFFUSE_BIT  = 6;
   localparam int SPECULAR_BIT = 7;

   // element slots, in emission order
   localparam int SLOT_COUNT = 15;
   localparam int SLOT_WIDTH = 4;
   localparam logic [SLOT_WIDTH-1:0] SLOT_POSITION = 4'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_BLEND    = 4'd1;
   localparam logic [SLOT_WIDTH-1:0] SLOT_NORMAL   = 4'd2;
   localparam logic [SLOT_WIDTH-1:0] SLOT_PSIZE    = 4'd3;
   localparam logic [SLOT_WIDTH-1:0] SLOT_DIFFUSE  = 4'd4;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SPECULAR = 4'd5;
   localparam logic [SLOT_WIDTH-1:0] SLOT_TEX0     = 4'd6;
   localparam logic [SLOT_WIDTH-1:0] SLOT_END      = 4'd14;

   // element type codes
   localparam logic [TYPE_WIDTH-1:0] TYPE_FLOAT1 = 5'd0;
   localparam logic [TYPE_WIDTH-1:0] TYPE_FLOAT3 = 5'd2;
   localparam logic [TYPE_WIDTH-1:0] TYPE_FLOAT4 = 5'd3;
   localparam logic [TYPE_WIDTH-1:0] TYPE_COLOR  = 5'd4;
   localparam logic [TYPE_WIDTH-1:0] TYPE_UNUSED = 5'd17;

   // usage codes
   localparam logic [USAGE_WIDTH-1:0] USE_POSITION    = 4'd0;
   localparam logic [USAGE_WIDTH-1:0] USE_BLENDWEIGHT = 4'd1;
   localparam logic [USAGE_WIDTH-1:0] USE_NORMAL      = 4'd3;
   localparam logic [USAGE_WIDTH-1:0] USE_PSIZE       = 4'd4;
   localparam logic [USAGE_WIDTH-1:0] USE_TEXCOORD    = 4'd5;
   localparam logic [USAGE_WIDTH-1:0] USE_POSITIONT   = 4'd9;
   localparam logic [USAGE_WIDTH-1:0] USE_COLOR       = 4'd10;

   localparam logic [UIDX_WIDTH-1:0] UIDX_DIFFUSE  = 3'd0;
   localparam logic [UIDX_WIDTH-1:0] UIDX_SPECULAR = 3'd1;

   localparam logic [STREAM_WIDTH-1:0] STREAM_ELEMENT = 8'd0;
   localparam logic [STREAM_WIDTH-1:0] STREAM_END     = 8'd255;

   // decoded code, handed from front to back
   typedef struct packed {
      logic                        has_pos;
      logic [1:0]                  pos_type;
      logic [USAGE_WIDTH-1:0]      pos_usage;
      logic                        has_blend;
      logic [1:0]                  blend_type;
      logic                        has_normal;
      logic                        has_psize;
      logic                        has_diffuse;
      logic                        has_specular;
      logic [TEX_COUNT_WIDTH-1:0]  tex_count;
      logic [TEX_FMT_WIDTH-1:0]    tex_fmt;
   } desc_type;

   // one vertex element
   typedef struct packed {
      logic [STREAM_WIDTH-1:0] stream_number;
      logic [OFFSET_WIDTH-1:0] element_offset;
      logic [TYPE_WIDTH-1:0]   element_type;
      logic [USAGE_WIDTH-1:0]  element_usage;
      logic [UIDX_WIDTH-1:0]   usage_index;
      logic                    is_terminator;
   } rsp_type;

   // texture format codes 0..3 give float2, float3, float4, float1
   function automatic logic [1:0] tex_elem_type(input logic [1:0] fmt);
      return fmt + 2'd1;
   endfunction

endpackage

`default_nettype wire

// File: src/fvfvd_queue.sv
// ----------------------------------------------------------------------------
// fvfvd_queue
// small first-in first-out queue of items of any packed type
// ----------------------------------------------------------------------------
`default_nettype none

module fvfvd_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type item_in,
   output logic          full,
   input  wire logic     pop,
   output item_type      item_out,
   output logic          empty
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   item_type               mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// File: src/fvfvd_front.sv
// ----------------------------------------------------------------------------
// fvfvd_front
// accepts format codes and classifies them into decoded descriptors
// ----------------------------------------------------------------------------
`default_nettype none

module fvfvd_front #(
   parameter int MAX_TEXCOORD_SETS = fvfvd_pkg::DEFAULT_MAX_TEXCOORD_SETS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [fvfvd_pkg::CODE_WIDTH-1:0] req_fvf_code,
   output logic                                 desc_push,
   output fvfvd_pkg::desc_type                  desc,
   input  wire logic                            desc_full
);

   localparam int TEX_LIMIT = (MAX_TEXCOORD_SETS < fvfvd_pkg::TEX_SETS_LIMIT) ?
                              MAX_TEXCOORD_SETS : fvfvd_pkg::TEX_SETS_LIMIT;

   logic                valid_ff, valid_in;
   fvfvd_pkg::desc_type desc_ff, desc_in, decoded;
   logic [15:0]         pos;
   logic [2:0]          blend_idx;
   logic [fvfvd_pkg::TEX_COUNT_WIDTH-1:0] tex_req;
   logic                take;

   assign req_full  = valid_ff && desc_full;
   assign take      = req_push && !req_full;
   assign desc_push = valid_ff;
   assign desc      = desc_ff;

   always_comb begin
      pos       = req_fvf_code[15:0] & fvfvd_pkg::POS_MASK;
      blend_idx = pos[3:1] - fvfvd_pkg::POS_XYZB1;
      tex_req   = req_fvf_code[fvfvd_pkg::TEX_COUNT_LSB +: fvfvd_pkg::TEX_COUNT_WIDTH];

      decoded            = '0;
      decoded.pos_type   = fvfvd_pkg::TYPE_FLOAT3[1:0];
      decoded.pos_usage  = fvfvd_pkg::USE_POSITION;
      if (pos == fvfvd_pkg::POS_XYZ) begin
         decoded.has_pos = 1'b1;
      end else if (pos == fvfvd_pkg::POS_XYZRHW) begin
         decoded.has_pos   = 1'b1;
         decoded.pos_type  = fvfvd_pkg::TYPE_FLOAT4[1:0];
         decoded.pos_usage = fvfvd_pkg::USE_POSITIONT;
      end else if (pos == fvfvd_pkg::POS_XYZW) begin
         decoded.has_pos  = 1'b1;
         decoded.pos_type = fvfvd_pkg::TYPE_FLOAT4[1:0];
      end else if (!pos[fvfvd_pkg::POS_W_BIT] && (pos[3:1] >= fvfvd_pkg::POS_XYZB1)) begin
         // xyzb1..xyzb5, weight count capped at four floats
         decoded.has_pos    = 1'b1;
         decoded.has_blend  = 1'b1;
         decoded.blend_type = (blend_idx > 3'd3) ? 2'd3 : blend_idx[1:0];
      end

      decoded.has_normal   = req_fvf_code[fvfvd_pkg::NORMAL_BIT];
      decoded.has_psize    = req_fvf_code[fvfvd_pkg::PSIZE_BIT];
      decoded.has_diffuse  = req_fvf_code[fvfvd_pkg::DIFFUSE_BIT];
      decoded.has_specular = req_fvf_code[fvfvd_pkg::SPECULAR_BIT];
      decoded.tex_count    = (tex_req > fvfvd_pkg::TEX_COUNT_WIDTH'(TEX_LIMIT)) ?
                             fvfvd_pkg::TEX_COUNT_WIDTH'(TEX_LIMIT) : tex_req;
      decoded.tex_fmt      = req_fvf_code[fvfvd_pkg::TEX_FMT_LSB +: fvfvd_pkg::TEX_FMT_WIDTH];

      valid_in = take ? 1'b1 : (valid_ff && desc_full);
      desc_in  = take ? decoded : desc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule

`default_nettype wire

// File: src/fvfvd_back.sv
// ----------------------------------------------------------------------------
// fvfvd_back
// walks the elements of one descriptor and queues them for the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module fvfvd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                desc_empty,
   input  wire fvfvd_pkg::desc_type desc,
   output logic                     desc_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output fvfvd_pkg::rsp_type       rsp
);

   localparam int SC = fvfvd_pkg::SLOT_COUNT;
   localparam int SW = fvfvd_pkg::SLOT_WIDTH;
   localparam int OW = fvfvd_pkg::OFFSET_WIDTH;

   logic [SC-1:0]      present, remaining, pick;
   logic [SC-1:0]      done_ff, done_in;
   logic [OW-1:0]      offset_ff, offset_in;
   logic [SW-1:0]      slot;
   logic [SW-1:0]      tex_slot;
   logic [fvfvd_pkg::UIDX_WIDTH-1:0] tex_idx;
   fvfvd_pkg::rsp_type elem;
   logic               emit, last, rsp_full;

   always_comb begin
      present = '0;
      present[fvfvd_pkg::SLOT_POSITION] = desc.has_pos;
      present[fvfvd_pkg::SLOT_BLEND]    = desc.has_blend;
      present[fvfvd_pkg::SLOT_NORMAL]   = desc.has_normal;
      present[fvfvd_pkg::SLOT_PSIZE]    = desc.has_psize;
      present[fvfvd_pkg::SLOT_DIFFUSE]  = desc.has_diffuse;
      present[fvfvd_pkg::SLOT_SPECULAR] = desc.has_specular;
      for (int i = 0; i < fvfvd_pkg::TEX_SETS_LIMIT; i++) begin
         present[int'(fvfvd_pkg::SLOT_TEX0) + i] =
            (fvfvd_pkg::TEX_COUNT_WIDTH'(i) < desc.tex_count);
      end
      present[fvfvd_pkg::SLOT_END] = 1'b1;

      remaining = present & ~done_ff;

      // lowest pending slot goes next
      slot = fvfvd_pkg::SLOT_END;
      for (int i = SC - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            slot = SW'(i);
         end
      end
      pick = SC'(1) << slot;

      tex_slot = slot - fvfvd_pkg::SLOT_TEX0;
      tex_idx  = tex_slot[fvfvd_pkg::UIDX_WIDTH-1:0];

      elem                = '0;
      elem.stream_number  = fvfvd_pkg::STREAM_ELEMENT;
      elem.element_offset = offset_ff;
      case (slot)
         fvfvd_pkg::SLOT_POSITION: begin
            elem.element_type  = fvfvd_pkg::TYPE_WIDTH'(desc.pos_type);
            elem.element_usage = desc.pos_usage;
         end
         fvfvd_pkg::SLOT_BLEND: begin
            elem.element_type  = fvfvd_pkg::TYPE_WIDTH'(desc.blend_type);
            elem.element_usage = fvfvd_pkg::USE_BLENDWEIGHT;
         end
         fvfvd_pkg::SLOT_NORMAL: begin
            elem.element_type  = fvfvd_pkg::TYPE_FLOAT3;
            elem.element_usage = fvfvd_pkg::USE_NORMAL;
         end
         fvfvd_pkg::SLOT_PSIZE: begin
            elem.element_type  = fvfvd_pkg::TYPE_FLOAT1;
            elem.element_usage = fvfvd_pkg::USE_PSIZE;
         end
         fvfvd_pkg::SLOT_DIFFUSE: begin
            elem.element_type  = fvfvd_pkg::TYPE_COLOR;
            elem.element_usage = fvfvd_pkg::USE_COLOR;
            elem.usage_index   = fvfvd_pkg::UIDX_DIFFUSE;
         end
         fvfvd_pkg::SLOT_SPECULAR: begin
            elem.element_type  = fvfvd_pkg::TYPE_COLOR;
            elem.element_usage = fvfvd_pkg::USE_COLOR;
            elem.usage_index   = fvfvd_pkg::UIDX_SPECULAR;
         end
         fvfvd_pkg::SLOT_END: begin
            elem.stream_number  = fvfvd_pkg::STREAM_END;
            elem.element_offset = '0;
            elem.element_type   = fvfvd_pkg::TYPE_UNUSED;
            elem.element_usage  = fvfvd_pkg::USE_POSITION;
            elem.is_terminator  = 1'b1;
         end
         default: begin
            // texture coordinate sets
            elem.element_type  = fvfvd_pkg::TYPE_WIDTH'(
               fvfvd_pkg::tex_elem_type(desc.tex_fmt[2*tex_idx +: 2]));
            elem.element_usage = fvfvd_pkg::USE_TEXCOORD;
            elem.usage_index   = tex_idx;
         end
      endcase

      emit     = !desc_empty && !rsp_full;
      last     = (slot == fvfvd_pkg::SLOT_END);
      desc_pop = emit && last;

      done_in   = done_ff;
      offset_in = offset_ff;
      if (emit) begin
         if (last) begin
            done_in   = '0;
            offset_in = '0;
         end else begin
            done_in   = done_ff | pick;
            offset_in = offset_ff + OW'({elem.element_type[1:0], 2'b00}) + OW'(4);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff   <= '0;
         offset_ff <= '0;
      end else begin
         done_ff   <= done_in;
         offset_ff <= offset_in;
      end
   end

   fvfvd_queue #(
      .item_type (fvfvd_pkg::rsp_type),
      .DEPTH     (fvfvd_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (emit),
      .item_in  (elem),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .item_out (rsp),
      .empty    (rsp_empty)
   );

endmodule

`default_nettype wire

// File: src/fvf_to_vertex_declaration_unit.sv
// ----------------------------------------------------------------------------
// fvf_to_vertex_declaration_unit
// turns flexible vertex format codes into lists of vertex elements
// ----------------------------------------------------------------------------
// usage
//  - request side: one 32-bit format code per item, taken when req_push is
//    high and req_full is low
//  - response side: a run of vertex elements per code (position, blend
//    weights, normal, point size, diffuse, specular, texture sets), always
//    closed by a terminator item with stream 255; the oldest element sits on
//    the rsp_ ports while rsp_empty is low and leaves on rsp_pop
//  - path: the first element of a code passes the front register, the
//    descriptor queue and the output queue on its way to the ports
//  - throughput: one element per cycle from the back-end walker while the
//    output queue has room; a code gives 1 to 15 items including its terminator
//  - receiver stall: the output queue fills, the walker holds, the two-entry
//    descriptor queue and the front register soak up further codes, then
//    req_full rises; nothing is dropped
//  - reset: synchronous, clears all queues and the walker; req_full is low
//    and rsp_empty high in the cycle after reset
// ----------------------------------------------------------------------------
`default_nettype none

module fvf_to_vertex_declaration_unit #(
   parameter int MAX_TEXCOORD_SETS = fvfvd_pkg::DEFAULT_MAX_TEXCOORD_SETS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request side
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [fvfvd_pkg::CODE_WIDTH-1:0]   req_fvf_code,
   // response side
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic [fvfvd_pkg::STREAM_WIDTH-1:0]      rsp_stream_number,
   output logic [fvfvd_pkg::OFFSET_WIDTH-1:0]      rsp_element_offset,
   output logic [fvfvd_pkg::TYPE_WIDTH-1:0]        rsp_element_type,
   output logic [fvfvd_pkg::USAGE_WIDTH-1:0]       rsp_element_usage,
   output logic [fvfvd_pkg::UIDX_WIDTH-1:0]        rsp_usage_index,
   output logic                                    rsp_is_terminator
);

   // front to descriptor queue
   logic                desc_push, desc_full;
   fvfvd_pkg::desc_type desc_front;
   // descriptor queue to back
   logic                desc_pop, desc_empty;
   fvfvd_pkg::desc_type desc_head;
   // back to ports
   fvfvd_pkg::rsp_type  rsp;

   // classify the code into a compact descriptor
   fvfvd_front #(
      .MAX_TEXCOORD_SETS (MAX_TEXCOORD_SETS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_fvf_code (req_fvf_code),
      .desc_push    (desc_push),
      .desc         (desc_front),
      .desc_full    (desc_full)
   );

   // decouples decoding from the element walk
   fvfvd_queue #(
      .item_type (fvfvd_pkg::desc_type),
      .DEPTH     (fvfvd_pkg::DESC_QUEUE_DEPTH)
   ) u_desc_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (desc_push),
      .item_in  (desc_front),
      .full     (desc_full),
      .pop      (desc_pop),
      .item_out (desc_head),
      .empty    (desc_empty)
   );

   // one element per cycle while the output queue has room, descriptor retired with its terminator
   fvfvd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_empty (desc_empty),
      .desc       (desc_head),
      .desc_pop   (desc_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_stream_number  = rsp.stream_number;
   assign rsp_element_offset = rsp.element_offset;
   assign rsp_element_type   = rsp.element_type;
   assign rsp_element_usage  = rsp.element_usage;
   assign rsp_usage_index    = rsp.usage_index;
   assign rsp_is_terminator  = rsp.is_terminator;

endmodule

`default_nettype wire

// File: src/fvfvd_checker.sv
// ----------------------------------------------------------------------------
// fvfvd_checker
// port-level checks of the vertex declaration unit
// ----------------------------------------------------------------------------
`default_nettype none

module fvfvd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_full,
   input wire logic                               rsp_empty,
   input wire logic                               rsp_pop,
   input wire logic [fvfvd_pkg::STREAM_WIDTH-1:0] rsp_stream_number,
   input wire logic [fvfvd_pkg::OFFSET_WIDTH-1:0] rsp_element_offset,
   input wire logic [fvfvd_pkg::TYPE_WIDTH-1:0]   rsp_element_type,
   input wire logic [fvfvd_pkg::USAGE_WIDTH-1:0]  rsp_element_usage,
   input wire logic [fvfvd_pkg::UIDX_WIDTH-1:0]   rsp_usage_index,
   input wire logic                               rsp_is_terminator
);

   // queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting element holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_stream_number)
         && $stable(rsp_element_offset) && $stable(rsp_element_type)
         && $stable(rsp_element_usage) && $stable(rsp_usage_index)
         && $stable(rsp_is_terminator)))
      else $error("waiting element changed");

   // terminator carries the end stream, unused type and zero offset
   a_terminator_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_terminator) |->
         (rsp_stream_number == fvfvd_pkg::STREAM_END
          && rsp_element_type == fvfvd_pkg::TYPE_UNUSED
          && rsp_element_offset == '0))
      else $error("malformed terminator");

   // ordinary elements live on stream zero with a float or colour type
   a_element_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_terminator) |->
         (rsp_stream_number == fvfvd_pkg::STREAM_ELEMENT
          && rsp_element_type <= fvfvd_pkg::TYPE_COLOR))
      else $error("malformed element");

endmodule

bind fvf_to_vertex_declaration_unit fvfvd_checker u_checker (.*);

`default_nettype wire
